// ----- design/trk_pkg.sv -----
`default_nettype none

package trk_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RatioW  = 4;
  localparam int unsigned PassesW = 4;
  localparam int unsigned LimitW  = CoordW + RatioW + 4;

  localparam logic [RatioW-1:0]  RatioReset  = 4'd5;
  localparam logic [PassesW-1:0] ExtraReset  = 4'd10;

  // configuration register indexes
  localparam logic CfgJumpRatio   = 1'b0;
  localparam logic CfgExtraPasses = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] frame;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } row_t;

  // one chain word: a stored row and its keep bit
  typedef struct packed {
    logic keep;
    row_t row;
  } cell_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- design/trk_cell.sv -----
`default_nettype none

module trk_cell
  import trk_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        shift_i,
  input  wire cell_t cell_i,
  output cell_t      cell_o
);

  logic keep_q;
  row_t row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (shift_i) begin
      keep_q <= cell_i.keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      row_q <= cell_i.row;
    end
  end

  assign cell_o.keep = keep_q;
  assign cell_o.row  = row_q;

endmodule

`default_nettype wire

// ----- design/trk_judge.sv -----
`default_nettype none

module trk_judge
  import trk_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [RatioW-1:0] ratio_i,
  input  wire  cell_t       head_i,
  input  wire               step_i,
  input  wire               pass_end_i,
  output logic              drop_o
);

  // last row kept at the start of this pass, drops included
  row_t              prev_q;
  logic              prev_vld_q;
  logic [CoordW-1:0] d_frame;
  logic [CoordW-1:0] d_x;
  logic [CoordW-1:0] d_y;
  logic [LimitW-1:0] limit;

  always_comb begin
    d_frame = (head_i.row.frame >= prev_q.frame) ? head_i.row.frame - prev_q.frame
                                                 : prev_q.frame - head_i.row.frame;
    d_x     = (head_i.row.x >= prev_q.x) ? head_i.row.x - prev_q.x : prev_q.x - head_i.row.x;
    d_y     = (head_i.row.y >= prev_q.y) ? head_i.row.y - prev_q.y : prev_q.y - head_i.row.y;
    limit   = {(LimitW-4)'(ratio_i * d_frame), 4'b0000};
    drop_o  = head_i.keep && prev_vld_q &&
              (({8'd0, d_x} >= limit) || ({8'd0, d_y} >= limit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vld_q <= 1'b0;
    end else if (step_i) begin
      if (pass_end_i) begin
        prev_vld_q <= 1'b0;
      end else if (head_i.keep) begin
        prev_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && head_i.keep) begin
      prev_q <= head_i.row;
    end
  end

endmodule

`default_nettype wire

// ----- design/track_jump_outlier_removal_core.sv -----
`default_nettype none

// channel | direction | handshake              | word
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid_i/in_ready_o   | frame_number, pos_x, pos_y, last_row
// out     | output    | out_valid_o/out_ready_i | out_frame, out_x, out_y, out_last, overflow
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index (0 jump_ratio, 1 extra_passes)
//
// Loading takes one word per cycle; each word shifts into the tail of the cell chain until it is full.
// After the last word, each cleanup pass rotates the whole chain once past the judge at
// the head, for at most extra_passes+1 passes.
// Emission is one more rotation, which stalls while a kept row waits for the output register.
// in_ready_o is low from the last word until emission ends; the output register lets
// the next track load while the final word waits.
// Reset clears keep bits and counters at once; the row payload is not reset.

module track_jump_outlier_removal_core
  import trk_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // row input
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [CoordW-1:0]  frame_number_i,
  input  wire  [CoordW-1:0]  pos_x_i,
  input  wire  [CoordW-1:0]  pos_y_i,
  input  wire                last_row_i,
  // surviving rows
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [CoordW-1:0]  out_frame_o,
  output logic [CoordW-1:0]  out_x_o,
  output logic [CoordW-1:0]  out_y_o,
  output logic               out_last_o,
  output logic               overflow_o,
  // configuration
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire                cfg_index_i,
  input  wire  [RatioW-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);
  localparam int unsigned IdxW = $clog2(MAX_ROWS);
  localparam logic [CntW-1:0] CntFull  = CntW'(MAX_ROWS);
  localparam logic [IdxW-1:0] StepLast = IdxW'(MAX_ROWS - 1);

  state_e state_q, state_d;

  logic [RatioW-1:0]  ratio_q;
  logic [PassesW-1:0] extra_q;
  logic [CntW-1:0]    row_cnt_q;   // rows stored in this track
  logic [CntW-1:0]    keep_cnt_q;  // rows still kept
  logic [IdxW-1:0]    step_q;      // position within a rotation
  logic [PassesW:0]   passes_q;    // passes run so far, current one included
  logic               removed_q;   // current pass dropped a row
  logic               ovf_q;

  cell_t chain_out [MAX_ROWS];
  cell_t chain_in  [MAX_ROWS];
  cell_t head;
  cell_t feed;

  logic in_acc;
  logic store;
  logic shift;
  logic step_last;
  logic drop;
  logic pass_step;
  logic slot_free;
  logic emit_word;
  logic more_pass;

  // ---------------------------------------------------------------------------
  // cell chain: data moves toward cell 0; the tail takes the feed word
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    if (i == MAX_ROWS - 1) begin : g_tail
      assign chain_in[i] = feed;
    end else begin : g_mid
      assign chain_in[i] = chain_out[i+1];
    end
    trk_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .cell_i  (chain_in[i]),
      .cell_o  (chain_out[i])
    );
  end

  assign head = chain_out[0];

  trk_judge u_judge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ratio_i    (ratio_q),
    .head_i     (head),
    .step_i     (pass_step),
    .pass_end_i (step_last),
    .drop_o     (drop)
  );

  assign cfg_ready_o = 1'b1;
  assign step_last   = (step_q == StepLast);
  assign slot_free   = !out_valid_o || out_ready_i;
  assign more_pass   = (removed_q || drop) && (passes_q <= {1'b0, extra_q});

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    in_acc     = 1'b0;
    store      = 1'b0;
    shift      = 1'b0;
    pass_step  = 1'b0;
    emit_word  = 1'b0;
    feed       = '{keep: 1'b0, row: head.row};
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        in_acc     = in_valid_i;
        store      = in_acc && (row_cnt_q != CntFull);
        shift      = store;
        feed       = '{keep: 1'b1,
                       row: '{frame: frame_number_i, x: pos_x_i, y: pos_y_i}};
        if (in_acc && last_row_i) begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        shift     = 1'b1;
        pass_step = 1'b1;
        feed      = '{keep: head.keep && !drop, row: head.row};
        if (step_last && !more_pass) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        shift     = !head.keep || slot_free;
        emit_word = head.keep && slot_free;
        if (shift && step_last) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // counters and flags
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= '0;
      keep_cnt_q <= '0;
      step_q     <= '0;
      passes_q   <= '0;
      removed_q  <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      if (store) begin
        row_cnt_q  <= row_cnt_q + 1'b1;
        keep_cnt_q <= keep_cnt_q + 1'b1;
      end else if ((pass_step && drop) || emit_word) begin
        keep_cnt_q <= keep_cnt_q - 1'b1;
      end
      if (in_acc && !store) begin
        ovf_q <= 1'b1;
      end
      if (in_acc && last_row_i) begin
        passes_q <= (PassesW+1)'(1);
      end else if (pass_step && step_last) begin
        passes_q <= passes_q + 1'b1;
      end
      if (pass_step) begin
        removed_q <= step_last ? 1'b0 : (removed_q || drop);
      end
      if (state_q != ST_LOAD && shift) begin
        step_q <= step_last ? '0 : step_q + 1'b1;
      end
      // track done: start over for the next one
      if (state_q == ST_EMIT && shift && step_last) begin
        row_cnt_q <= '0;
        ovf_q     <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioReset;
      extra_q <= ExtraReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgJumpRatio:   ratio_q <= cfg_data_i;
        CfgExtraPasses: extra_q <= cfg_data_i;
        default:        ratio_q <= ratio_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit_word) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_word) begin
      out_frame_o <= head.row.frame;
      out_x_o     <= head.row.x;
      out_y_o     <= head.row.y;
      out_last_o  <= (keep_cnt_q == CntW'(1));
      overflow_o  <= ovf_q;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_keep_le_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_cnt_q <= row_cnt_q)
    else $error("more kept rows than stored rows");

  a_pass_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PASS |-> passes_q <= {1'b0, extra_q} + 1'b1)
    else $error("cleanup pass limit exceeded");

  a_track_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_LOAD) |=> keep_cnt_q == '0)
    else $error("kept rows left after emission");

  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("output word outside emission");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS) |=> $stable(row_cnt_q))
    else $error("row count moved during cleanup");

endmodule

`default_nettype wire

// ----- test/track_jump_outlier_removal_core_test.sv -----
`timescale 1ns / 100ps

module track_jump_outlier_removal_core_test
  import trk_pkg::*;
;

  localparam int unsigned MaxRows    = 64;
  localparam int unsigned CycleCap   = 600000;
  localparam int unsigned HoldCycles = 1500;  // long receiver stall, fills the block
  localparam int unsigned Settle     = 100;   // quiet cycles after the last surviving row
  localparam int unsigned PhaseRows  = 74;
  localparam int unsigned NumPhases  = 5;

  // one expected output word
  typedef struct packed {
    row_t row;
    logic last;
    logic ovf;
  } survivor_t;

  // Tracks the rows of the open track, prunes them when the last row lands,
  // and holds the surviving rows in order until the block emits them.
  class outlier_board;
    row_t               track_rows[$];
    bit                 alive[MaxRows];
    logic               dropped;
    logic [RatioW-1:0]  ratio;
    logic [PassesW-1:0] extra;
    survivor_t          survivors_due[$];
    int                 errors;

    function new();
      ratio   = RatioReset;
      extra   = ExtraReset;
      dropped = 1'b0;
      errors  = 0;
      foreach (alive[i]) alive[i] = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [RatioW-1:0] data);
      if (idx == CfgJumpRatio) begin
        ratio = data;
      end else begin
        extra = data;
      end
    endfunction

    function int unsigned gap(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
      return (a >= b) ? int'(a - b) : int'(b - a);
    endfunction

    // one cleanup sweep over the kept rows; returns how many were cut
    function int sweep_once();
      int unsigned order[$];
      bit          cut[MaxRows];
      int unsigned lim;
      int          removed;
      row_t        a;
      row_t        b;
      removed = 0;
      foreach (cut[i]) cut[i] = 1'b0;
      foreach (track_rows[i]) if (alive[i]) order = {order, unsigned'(i)};
      if (order.size() < 2) return 0;
      for (int i = 0; i + 1 < order.size(); i++) begin
        a   = track_rows[order[i]];
        b   = track_rows[order[i+1]];
        lim = (int'(ratio) * gap(a.frame, b.frame)) << 4;
        if (gap(a.x, b.x) >= lim || gap(a.y, b.y) >= lim) cut[order[i+1]] = 1'b1;
      end
      foreach (track_rows[i]) begin
        if (cut[i] && alive[i]) begin
          alive[i] = 1'b0;
          removed++;
        end
      end
      return removed;
    endfunction

    function void note_row(row_t r, logic last);
      int        passes;
      int        tail;
      survivor_t s;
      if (track_rows.size() < MaxRows) begin
        track_rows = {track_rows, r};
        alive[track_rows.size()-1] = 1'b1;
      end else begin
        dropped = 1'b1;  // no room; a dropped last row still closes the track
      end
      if (!last) return;
      passes = 1;
      if (sweep_once() != 0) begin
        while (passes <= int'(extra)) begin
          passes++;
          if (sweep_once() == 0) break;
        end
      end
      tail = 0;
      foreach (track_rows[i]) if (alive[i]) tail = i;
      foreach (track_rows[i]) begin
        if (alive[i]) begin
          s.row  = track_rows[i];
          s.last = (i == tail);
          s.ovf  = dropped;
          survivors_due = {survivors_due, s};
        end
      end
      track_rows.delete();
      foreach (alive[i]) alive[i] = 1'b0;
      dropped = 1'b0;
    endfunction

    function void flag_field(string name, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    endfunction

    function void check_result(logic [CoordW-1:0] frame, logic [CoordW-1:0] x,
                               logic [CoordW-1:0] y, logic last, logic ovf);
      survivor_t want;
      if (survivors_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, frame %h x %h y %h last %b ovf %b",
                 $time, frame, x, y, last, ovf);
        return;
      end
      want = survivors_due.pop_front();
      if (frame !== want.row.frame) flag_field("out_frame", want.row.frame, frame);
      if (x !== want.row.x) flag_field("out_x", want.row.x, x);
      if (y !== want.row.y) flag_field("out_y", want.row.y, y);
      if (last !== want.last) flag_field("out_last", CoordW'(want.last), CoordW'(last));
      if (ovf !== want.ovf) flag_field("overflow", CoordW'(want.ovf), CoordW'(ovf));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CoordW-1:0]  frame_number_i;
  logic [CoordW-1:0]  pos_x_i;
  logic [CoordW-1:0]  pos_y_i;
  logic               last_row_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CoordW-1:0]  out_frame_o;
  logic [CoordW-1:0]  out_x_o;
  logic [CoordW-1:0]  out_y_o;
  logic               out_last_o;
  logic               overflow_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [RatioW-1:0]  cfg_data_i;

  outlier_board       sb;
  bit                 steady   = 1'b0;  // no idling on either side while set
  bit                 press_go = 1'b0;  // kicks off the long receiver stall
  int unsigned        cycles   = 0;
  int unsigned        phase_rows;
  logic [RatioW-1:0]  phase_ratio [NumPhases];
  logic [PassesW-1:0] phase_extra [NumPhases];

  track_jump_outlier_removal_core #(
    .MAX_ROWS(MaxRows)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .frame_number_i,
    .pos_x_i,
    .pos_y_i,
    .last_row_i,
    .out_valid_o,
    .out_ready_i,
    .out_frame_o,
    .out_x_o,
    .out_y_o,
    .out_last_o,
    .overflow_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleCap) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random back-pressure, plus one long hold-off once press_go rises.
  // The hold-off count lives here so the stall length does not depend on the sender.
  initial begin : receiver
    int unsigned held;
    held = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (press_go && held < HoldCycles) begin
        held++;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // Output words are sampled at the edge, before the block updates anything.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_frame_o, out_x_o, out_y_o, out_last_o, overflow_o);
    end
  end

  // Offers one row word and holds it until the block takes it. Valid stays
  // high on exit so the next word can follow without a gap.
  task automatic send_row(row_t r, logic last);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    frame_number_i <= r.frame;
    pos_x_i        <= r.x;
    pos_y_i        <= r.y;
    last_row_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_row(r, last);
    phase_rows++;
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(logic idx, logic [RatioW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Wait until every survivor is out, then let the block settle.
  task automatic drain();
    while (sb.survivors_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // One track. Most tracks move smoothly with the odd position spike; some are
  // pure noise, some have repeated or backward frame numbers.
  task automatic send_track(int unsigned len);
    int unsigned style;
    int          f, x, y, vx, vy, step, top;
    row_t        r;
    style = $urandom_range(99);
    top   = 16 * int'(sb.ratio) + 24;  // velocities straddle the threshold
    f     = $urandom_range(65535);
    x     = $urandom_range(65535);
    y     = $urandom_range(65535);
    vx    = int'($urandom_range(2 * top)) - top;
    vy    = int'($urandom_range(2 * top)) - top;
    for (int unsigned i = 0; i < len; i++) begin
      if (style < 20) begin
        r.frame = CoordW'($urandom);
        r.x     = CoordW'($urandom);
        r.y     = CoordW'($urandom);
      end else begin
        if (style < 35) begin
          step = int'($urandom_range(4)) - 2;  // repeats and reversals
        end else begin
          step = $urandom_range(1, 4);
        end
        f += step;
        x += vx * step + int'($urandom_range(16)) - 8;
        y += vy * step + int'($urandom_range(16)) - 8;
        r.frame = f[CoordW-1:0];
        r.x     = x[CoordW-1:0];
        r.y     = y[CoordW-1:0];
        if ($urandom_range(7) == 0) begin
          r.x = CoordW'(x + int'($urandom_range(4000)) - 2000);
        end
        if ($urandom_range(9) == 0) begin
          r.y = CoordW'(y + int'($urandom_range(4000)) - 2000);
        end
      end
      send_row(r, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned len;
    sb = new();
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    frame_number_i <= '0;
    pos_x_i        <= '0;
    pos_y_i        <= '0;
    last_row_i     <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CfgJumpRatio;
    cfg_data_i     <= '0;
    // register settings per phase: extremes first, then a few in between
    phase_ratio[0] = 4'd0;  phase_extra[0] = 4'd15;
    phase_ratio[1] = 4'd15; phase_extra[1] = 4'd0;
    phase_ratio[2] = 4'd3;  phase_extra[2] = 4'd2;
    phase_ratio[3] = 4'd1;  phase_extra[3] = 4'd1;
    phase_ratio[4] = 4'd9;  phase_extra[4] = 4'd10;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tracks at the reset settings (ratio 5, 10 extra passes).
    // single row: too short to clean
    send_row({16'h0000, 16'h0000, 16'h0000}, 1'b1);
    // repeated frame number: later row goes
    send_row({16'd100, 16'h0100, 16'h0200}, 1'b0);
    send_row({16'd100, 16'h0100, 16'h0200}, 1'b1);
    // field extremes, every bit both ways
    send_row({16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_row({16'h0000, 16'h0000, 16'h0000}, 1'b0);
    send_row({16'hFFFE, 16'h0000, 16'hFFFF}, 1'b0);
    send_row({16'h0001, 16'hFFFF, 16'h0000}, 1'b1);
    // a run of three far-off rows: needs several passes to strip
    send_row({16'd10, 16'd1000, 16'd500}, 1'b0);
    send_row({16'd11, 16'd1016, 16'd510}, 1'b0);
    send_row({16'd12, 16'd1032, 16'd520}, 1'b0);
    send_row({16'd13, 16'd4000, 16'd530}, 1'b0);
    send_row({16'd14, 16'd4010, 16'd540}, 1'b0);
    send_row({16'd15, 16'd4020, 16'd550}, 1'b0);
    send_row({16'd16, 16'd1080, 16'd560}, 1'b0);
    send_row({16'd17, 16'd1096, 16'd570}, 1'b1);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CfgJumpRatio, phase_ratio[p]);
      write_reg(CfgExtraPasses, phase_extra[p]);
      cfg_valid_i <= 1'b0;
      steady      <= (p == 2);          // one phase with no idling at all
      if (p == 1) press_go <= 1'b1;     // output stalls while tracks pile in
      phase_rows = 0;
      if (p == 0) send_track(66);       // over capacity, last row dropped
      if (p == 3) send_track(64);       // exactly full
      while (phase_rows < PhaseRows) begin
        len = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        send_track(len);
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
